### hdl/bfp_pkg.sv
`default_nettype none

package bfp_pkg;

  localparam logic [7:0] TYPE_APP_MAX = 8'hEF;
  localparam logic [7:0] TYPE_START   = 8'hF0;
  localparam logic [7:0] TYPE_DATA    = 8'hF1;
  localparam logic [7:0] TYPE_ACK     = 8'hF2;
  localparam logic [7:0] TYPE_NACK    = 8'hF3;
  localparam logic [7:0] TYPE_END     = 8'hF4;
  localparam logic [7:0] TYPE_ABORT   = 8'hF5;

  localparam logic [8:0] HDR_BYTES   = 9'd2;
  localparam logic [8:0] COUNT_MAX   = 9'd511;
  localparam logic [8:0] FIELD_BYTES = 9'd12;

  localparam logic [7:0] START_LEN = 8'd12;
  localparam logic [7:0] SHORT_LEN = 8'd3;
  localparam logic [7:0] END_LEN   = 8'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_MALFORMED   = 2'd1;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       end_of_frame;
  } in_beat_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        frame_done;
    logic [1:0]  parse_status;
    logic [7:0]  frame_type;
    logic [7:0]  payload_len;
    logic [7:0]  transfer_id;
    logic [7:0]  field_a;
    logic [7:0]  field_b;
    logic [7:0]  field_c;
    logic [31:0] total_length;
    logic [31:0] crc_word;
  } out_beat_t;

  typedef struct packed {
    logic [8:0]  byte_count;
    logic [7:0]  length_byte;
    logic [7:0]  type_byte;
    logic [7:0]  xfer_reg;
    logic [7:0]  field_a_reg;
    logic [7:0]  field_b_reg;
    logic [7:0]  field_c_reg;
    logic [31:0] total_len_reg;
    logic [31:0] crc_reg;
  } frame_state_t;

  localparam frame_state_t STATE_CLEAR = '0;

endpackage

`default_nettype wire

### hdl/bfp_decode.sv
`default_nettype none

module bfp_decode (
  input  wire  bfp_pkg::frame_state_t state,
  input  wire  bfp_pkg::in_beat_t     beat,
  output bfp_pkg::frame_state_t       state_next,
  output bfp_pkg::out_beat_t          result
);

  always_comb begin
    bfp_pkg::frame_state_t s;
    logic [7:0] b;
    logic [8:0] off;
    logic [8:0] p;
    logic [1:0] pos;
    logic [8:0] count;
    logic       pv;
    logic       is_fw;
    logic [1:0] status;
    logic       len_ok;

    s      = state;
    b      = beat.rx_byte;
    off    = state.byte_count;
    p      = off - bfp_pkg::HDR_BYTES;
    pos    = p[1:0] - 2'd2;
    pv     = 1'b0;
    is_fw  = 1'b0;
    len_ok = 1'b0;
    result = '0;

    if (off == 9'd0) begin
      s.length_byte = b;
    end else if (off == 9'd1) begin
      s.type_byte = b;
    end else begin
      is_fw = (s.type_byte >= bfp_pkg::TYPE_START) && (s.type_byte <= bfp_pkg::TYPE_ABORT);
      if (s.type_byte <= bfp_pkg::TYPE_APP_MAX) begin
        pv = 1'b1;
      end else if (s.type_byte == bfp_pkg::TYPE_DATA && p >= 9'd2) begin
        pv = 1'b1;
      end
      if (is_fw && p < bfp_pkg::FIELD_BYTES) begin
        if (p == 9'd0) begin
          s.xfer_reg = b;
        end else if (p == 9'd1) begin
          s.field_a_reg = b;
        end else if (s.type_byte == bfp_pkg::TYPE_START) begin
          if (p < 9'd6) begin
            s.total_len_reg[8*pos +: 8] = b;
          end else if (p == 9'd6) begin
            s.field_b_reg = b;
          end else if (p == 9'd7) begin
            s.field_c_reg = b;
          end else begin
            s.crc_reg[8*p[1:0] +: 8] = b;
          end
        end else if (p == 9'd2 && (s.type_byte == bfp_pkg::TYPE_ACK ||
                                   s.type_byte == bfp_pkg::TYPE_NACK ||
                                   s.type_byte == bfp_pkg::TYPE_ABORT)) begin
          s.field_b_reg = b;
        end
      end
    end

    count        = (off < bfp_pkg::COUNT_MAX) ? off + 9'd1 : bfp_pkg::COUNT_MAX;
    s.byte_count = count;

    result.payload_valid = pv;
    result.payload_byte  = pv ? b : 8'd0;

    status = bfp_pkg::ST_OK;
    if (beat.end_of_frame) begin
      result.frame_done  = 1'b1;
      result.frame_type  = (count >= 9'd2) ? s.type_byte : 8'd0;
      result.payload_len = s.length_byte;
      len_ok = (count >= 9'd2) && ({1'b0, s.length_byte} + bfp_pkg::HDR_BYTES == count);
      priority if (!len_ok) begin
        status = bfp_pkg::ST_MALFORMED;
      end else if (s.type_byte <= bfp_pkg::TYPE_APP_MAX) begin
        status = bfp_pkg::ST_OK;
      end else if (s.type_byte == bfp_pkg::TYPE_START) begin
        status = (s.length_byte == bfp_pkg::START_LEN) ? bfp_pkg::ST_OK : bfp_pkg::ST_MALFORMED;
      end else if (s.type_byte == bfp_pkg::TYPE_DATA) begin
        status = (s.length_byte >= bfp_pkg::SHORT_LEN) ? bfp_pkg::ST_OK : bfp_pkg::ST_MALFORMED;
      end else if (s.type_byte == bfp_pkg::TYPE_ACK || s.type_byte == bfp_pkg::TYPE_NACK ||
                   s.type_byte == bfp_pkg::TYPE_ABORT) begin
        status = (s.length_byte == bfp_pkg::SHORT_LEN) ? bfp_pkg::ST_OK : bfp_pkg::ST_MALFORMED;
      end else if (s.type_byte == bfp_pkg::TYPE_END) begin
        status = (s.length_byte == bfp_pkg::END_LEN) ? bfp_pkg::ST_OK : bfp_pkg::ST_MALFORMED;
      end else begin
        status = bfp_pkg::ST_UNSUPPORTED;
      end
      result.parse_status = status;
      // decoded fields only for a clean framework frame
      if (len_ok && s.type_byte > bfp_pkg::TYPE_APP_MAX && status == bfp_pkg::ST_OK) begin
        result.transfer_id  = s.xfer_reg;
        result.field_a      = s.field_a_reg;
        result.field_b      = s.field_b_reg;
        result.field_c      = s.field_c_reg;
        result.total_length = s.total_len_reg;
        result.crc_word     = s.crc_reg;
      end
      s = bfp_pkg::STATE_CLEAR;
    end

    state_next = s;
  end

endmodule

`default_nettype wire

### hdl/bulk_frame_parser_unit.sv
// bulk_frame_parser_unit: byte-serial parser for length/type framed links.
// byte channel: one received frame byte per beat on byte_data, with
//   end_of_frame set on the last byte of a frame.
// result channel: exactly one result beat per byte beat, in order. It
//   carries any opaque payload byte, and on the last byte of a frame the
//   parse status and the decoded fields (zero when the frame is not a
//   well-formed framework frame).
// Throughput: one byte per cycle, sustained, with no stall on either side.
// Path: a byte taken on byte_data goes first into the input register and
//   then into the result register, from which its result beat is taken.
// The parse itself sits in one combinational step between the input
//   register and the result register; frame state updates as a byte moves.
// Stall: while result_stall is high on a valid result the result register
//   holds; the input register keeps taking a byte until it too is full,
//   then byte_stall rises right after that edge, and drops with result_stall.
// Reset (rst, synchronous): empties both registers and clears the frame
//   state, so the next byte is taken as the length byte of a new frame.
`default_nettype none

module bulk_frame_parser_unit (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 byte_valid,
  output logic                byte_stall,
  input  wire  bfp_pkg::in_beat_t byte_data,
  output logic                result_valid,
  input  wire                 result_stall,
  output bfp_pkg::out_beat_t  result_data
);

  logic                  hold_valid;
  bfp_pkg::in_beat_t     hold_beat;
  bfp_pkg::frame_state_t state;
  bfp_pkg::frame_state_t state_next;
  bfp_pkg::out_beat_t    result_next;
  logic                  advance;
  logic                  move;

  assign advance    = !result_valid || !result_stall;
  assign move       = hold_valid && advance;
  assign byte_stall = hold_valid && !advance;

  bfp_decode u_decode (
    .state      (state),
    .beat       (hold_beat),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!byte_stall) begin
      hold_valid <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      hold_beat <= byte_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bfp_pkg::STATE_CLEAR;
    end else if (move) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      result_data <= result_next;
    end
  end

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_data.frame_done |->
      result_data.parse_status == bfp_pkg::ST_OK && result_data.frame_type == 8'd0 &&
      result_data.payload_len == 8'd0)
    else $error("fields set on a beat that does not end a frame");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result_data.parse_status != 2'd3)
    else $error("undefined parse status");

  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    move && hold_beat.end_of_frame |=> state.byte_count == 9'd0)
    else $error("frame state not cleared after last byte");

  a_error_no_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_data.parse_status != bfp_pkg::ST_OK |->
      result_data.transfer_id == 8'd0 && result_data.total_length == 32'd0 &&
      result_data.crc_word == 32'd0)
    else $error("decoded fields on a failed frame");

  a_count_follows: assert property (@(posedge clk) disable iff (rst)
    move && !hold_beat.end_of_frame && state.byte_count != bfp_pkg::COUNT_MAX |=>
      state.byte_count == $past(state.byte_count) + 9'd1)
    else $error("byte count did not advance");

endmodule

`default_nettype wire
